>>> hdl/tsfa_pkg.sv
// ----------------------------------------------------------------------------
// tsfa_pkg
// Shared types, codes and helper functions for the touch sample filter.
// ----------------------------------------------------------------------------
package tsfa_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int SET_SIZE    = 4;
    localparam int COUNT_W     = 2;
    localparam int STORE_DEPTH = SET_SIZE - 1;
    localparam int SUM_W       = SAMPLE_W + 2;

    localparam logic [COUNT_W-1:0]  LAST_INDEX  = COUNT_W'(SET_SIZE - 1);
    localparam logic [SAMPLE_W-1:0] LIMIT_RESET = SAMPLE_W'(10);

    // operation codes of an input word
    localparam logic OP_CONVERT = 1'b0;
    localparam logic OP_EVENT   = 1'b1;

    typedef enum logic [1:0] {
        REP_NONE    = 2'd0,
        REP_RELEASE = 2'd1,
        REP_TOUCH   = 2'd2
    } report_t;

    typedef enum logic [1:0] {
        STEP_CONVERT   = 2'd0,
        STEP_WAIT_DOWN = 2'd1,
        STEP_WAIT_UP   = 2'd2
    } step_t;

    // what one lane found on its axis
    typedef struct packed {
        logic                reject;
        logic [SAMPLE_W-1:0] avg;
    } lane_result_t;

    // one result word
    typedef struct packed {
        report_t             report;
        logic [SAMPLE_W-1:0] x_position;
        logic [SAMPLE_W-1:0] y_position;
        step_t               next_step;
    } result_t;

    // merge stage decisions
    typedef struct packed {
        result_t            result;
        logic [COUNT_W-1:0] count_next;
    } ctrl_t;

    // true when v is farther than lim from the truncated mean of a and b
    function automatic logic strays(
        input logic [SAMPLE_W-1:0] a,
        input logic [SAMPLE_W-1:0] b,
        input logic [SAMPLE_W-1:0] v,
        input logic [SAMPLE_W-1:0] lim
    );
        logic [SAMPLE_W:0]   pair;
        logic [SAMPLE_W-1:0] mean;
        logic [SAMPLE_W-1:0] diff;
        pair = {1'b0, a} + {1'b0, b};
        mean = pair[SAMPLE_W:1];
        diff = (v > mean) ? (v - mean) : (mean - v);
        return diff > lim;
    endfunction

endpackage

>>> hdl/tsfa_if.sv
// ----------------------------------------------------------------------------
// tsfa_in_if / tsfa_out_if
// Valid/ready channels for sample words and result words.
// ----------------------------------------------------------------------------
interface tsfa_in_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic                          pen_up;
    logic [tsfa_pkg::SAMPLE_W-1:0] x_sample;
    logic [tsfa_pkg::SAMPLE_W-1:0] y_sample;

    modport source (output valid, output operation, output pen_up,
                    output x_sample, output y_sample, input ready);
    modport sink   (input valid, input operation, input pen_up,
                    input x_sample, input y_sample, output ready);
endinterface

interface tsfa_out_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    report;
    logic [tsfa_pkg::SAMPLE_W-1:0] x_position;
    logic [tsfa_pkg::SAMPLE_W-1:0] y_position;
    logic [1:0]                    next_step;

    modport source (output valid, output report, output x_position,
                    output y_position, output next_step, input ready);
    modport sink   (input valid, input report, input x_position,
                    input y_position, input next_step, output ready);
endinterface

>>> hdl/tsfa_lane.sv
// ----------------------------------------------------------------------------
// tsfa_lane
// One axis of the filter: holds the first three samples of a set, checks
// both jitter windows and forms the four-sample average with the new sample.
// ----------------------------------------------------------------------------
module tsfa_lane
(
    input  logic                                  clk,
    input  logic                                  store_en,
    input  logic [tsfa_pkg::COUNT_W-1:0]          index,
    input  logic [tsfa_pkg::SAMPLE_W-1:0]         sample,
    input  logic [tsfa_pkg::SAMPLE_W-1:0]         limit,
    output tsfa_pkg::lane_result_t                result
);

    logic [tsfa_pkg::SAMPLE_W-1:0] store_reg [0:tsfa_pkg::STORE_DEPTH-1];
    logic [tsfa_pkg::SUM_W-1:0]    sum;
    logic                          stray_first;
    logic                          stray_second;

    // sample store, no reset: each entry is written before it is read
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < tsfa_pkg::STORE_DEPTH; i++)
        begin
            if (store_en && (index == tsfa_pkg::COUNT_W'(i)))
            begin
                store_reg[i] <= sample;
            end
        end
    end

    // jitter windows: third vs first pair, fourth (incoming) vs second pair
    always_comb
    begin
        stray_first  = tsfa_pkg::strays(store_reg[0], store_reg[1], store_reg[2], limit);
        stray_second = tsfa_pkg::strays(store_reg[1], store_reg[2], sample, limit);
        sum = tsfa_pkg::SUM_W'(store_reg[0]) + tsfa_pkg::SUM_W'(store_reg[1])
            + tsfa_pkg::SUM_W'(store_reg[2]) + tsfa_pkg::SUM_W'(sample);
        result.reject = stray_first || stray_second;
        result.avg    = sum[tsfa_pkg::SUM_W-1:2];
    end

endmodule

>>> hdl/tsfa_merge.sv
// ----------------------------------------------------------------------------
// tsfa_merge
// Combines the X and Y lane findings with the word's flags into the result
// word and the next sample count.
// ----------------------------------------------------------------------------
module tsfa_merge
(
    input  logic                         operation,
    input  logic                         pen_up,
    input  logic [tsfa_pkg::COUNT_W-1:0] count,
    input  tsfa_pkg::lane_result_t       x_lane,
    input  tsfa_pkg::lane_result_t       y_lane,
    output tsfa_pkg::ctrl_t              ctrl
);

    // decision tree: pen up, event, set complete, partial set
    always_comb
    begin
        ctrl.result.report     = tsfa_pkg::REP_NONE;
        ctrl.result.x_position = '0;
        ctrl.result.y_position = '0;
        ctrl.result.next_step  = tsfa_pkg::STEP_CONVERT;
        ctrl.count_next        = count;

        if (pen_up)
        begin
            ctrl.result.report    = tsfa_pkg::REP_RELEASE;
            ctrl.result.next_step = tsfa_pkg::STEP_WAIT_DOWN;
            if (operation == tsfa_pkg::OP_CONVERT)
            begin
                ctrl.count_next = '0;
            end
        end
        else if (operation == tsfa_pkg::OP_EVENT)
        begin
            ctrl.result.next_step = tsfa_pkg::STEP_CONVERT;
        end
        else if (count == tsfa_pkg::LAST_INDEX)
        begin
            if (!(x_lane.reject || y_lane.reject))
            begin
                ctrl.result.report     = tsfa_pkg::REP_TOUCH;
                ctrl.result.x_position = x_lane.avg;
                ctrl.result.y_position = y_lane.avg;
            end
            ctrl.result.next_step = tsfa_pkg::STEP_WAIT_UP;
            ctrl.count_next       = '0;
        end
        else
        begin
            ctrl.result.next_step = tsfa_pkg::STEP_CONVERT;
            ctrl.count_next       = count + tsfa_pkg::COUNT_W'(1);
        end
    end

endmodule

>>> hdl/tsfa_out_buf.sv
// ----------------------------------------------------------------------------
// tsfa_out_buf
// Two-word output buffer: a head register plus a skid register, so a new
// word is taken while the head word is stalled.
// ----------------------------------------------------------------------------
module tsfa_out_buf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tsfa_pkg::result_t data,
    output logic              ready,
    tsfa_out_if.source        results
);

    logic              main_valid_reg;
    logic              skid_valid_reg;
    tsfa_pkg::result_t main_reg;
    tsfa_pkg::result_t skid_reg;
    logic              pop;

    assign pop   = main_valid_reg && results.ready;
    assign ready = !skid_valid_reg;

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg)
        begin
            main_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            main_reg <= skid_valid_reg ? skid_reg : data;
        end
        else if (!main_valid_reg)
        begin
            main_reg <= data;
        end
        else if (push)
        begin
            skid_reg <= data;
        end
    end

    assign results.valid      = main_valid_reg;
    assign results.report     = main_reg.report;
    assign results.x_position = main_reg.x_position;
    assign results.y_position = main_reg.y_position;
    assign results.next_step  = main_reg.next_step;

    // skid holds a word only behind a head word
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid word without head word");

    // a word pushed onto a stalled head lands in the skid
    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (main_valid_reg && !results.ready && push) |=> skid_valid_reg)
        else $error("word lost while head stalled");

    // draining the skid moves it to the head
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && skid_valid_reg) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid word not moved to head");

endmodule

>>> hdl/touch_sample_filter_average.sv
// A word accepted at a clock edge is registered into the output buffer at that edge.
// Throughput: one sample word per cycle while the skid register is empty; the X and Y lanes
// and the merge stage are combinational, and a two-word output buffer takes a word while
// a result is stalled. Reset clears the sample count and the output buffer
// and sets the jitter limit to 10; the sample stores hold no reset value.
// ----------------------------------------------------------------------------
// touch_sample_filter_average
// Four-sample jitter filter and sequencer for a resistive touch controller,
// built from an X lane and a Y lane, a merge stage and an output buffer.
// ----------------------------------------------------------------------------
module touch_sample_filter_average
(
    input  logic                          clk,
    input  logic                          rst_n,
    tsfa_in_if.sink                       samples,
    tsfa_out_if.source                    results,
    input  logic                          cfg_we,
    input  logic [tsfa_pkg::SAMPLE_W-1:0] cfg_wdata
);

    logic [tsfa_pkg::SAMPLE_W-1:0] limit_reg;
    logic [tsfa_pkg::COUNT_W-1:0]  count_reg;
    logic                          accept;
    logic                          store_en;
    logic                          buf_ready;
    tsfa_pkg::lane_result_t        x_lane;
    tsfa_pkg::lane_result_t        y_lane;
    tsfa_pkg::ctrl_t               ctrl;

    assign samples.ready = buf_ready;
    assign accept        = samples.valid && buf_ready;
    assign store_en      = accept && !samples.pen_up
                         && (samples.operation == tsfa_pkg::OP_CONVERT);

    // jitter limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= tsfa_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    // sample count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= ctrl.count_next;
        end
    end

    tsfa_lane u_x_lane
    (
        .clk      (clk),
        .store_en (store_en),
        .index    (count_reg),
        .sample   (samples.x_sample),
        .limit    (limit_reg),
        .result   (x_lane)
    );

    tsfa_lane u_y_lane
    (
        .clk      (clk),
        .store_en (store_en),
        .index    (count_reg),
        .sample   (samples.y_sample),
        .limit    (limit_reg),
        .result   (y_lane)
    );

    tsfa_merge u_merge
    (
        .operation (samples.operation),
        .pen_up    (samples.pen_up),
        .count     (count_reg),
        .x_lane    (x_lane),
        .y_lane    (y_lane),
        .ctrl      (ctrl)
    );

    tsfa_out_buf u_out_buf
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (accept),
        .data    (ctrl.result),
        .ready   (buf_ready),
        .results (results)
    );

endmodule
